// ===== rtl/pna_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pna_pkg
// Shared constants, codes and types of the pedestal and noise accumulator.
// ----------------------------------------------------------------------------
package pna_pkg;

	// default parameter values
	localparam int CHANNELS_DEF   = 1024;
	localparam int TIME_BINS_DEF  = 3;
	localparam int ADC_BITS_DEF   = 12;
	localparam int COUNT_BITS_DEF = 16;

	// fixed field widths
	localparam int CMD_W     = 2;
	localparam int CHAN_W    = 10;
	localparam int TB_W      = 2;
	localparam int ADC_W     = 12;
	localparam int PED_W     = 16;
	localparam int NOISE_W   = 12;
	localparam int STATUS_W  = 3;
	localparam int MEAN_W    = 16;
	localparam int RMS_W     = 15;
	localparam int COUNT_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;
	localparam int REF_W     = PED_W + NOISE_W;

	// commands
	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACC  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	// result status
	localparam logic [STATUS_W-1:0] ST_ACC  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO = 3'd1;
	localparam logic [STATUS_W-1:0] ST_CUT  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_SAT  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_LOAD = 3'd4;
	localparam logic [STATUS_W-1:0] ST_READ = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CUT_EN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CUT_F  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MERGE  = 2'd2;

	localparam logic [CFG_DAT_W-1:0] CUT_FACTOR_RST = 8'd48;
	localparam logic [RMS_W-1:0]     DEAD_RMS       = 15'd1600;
	localparam logic [RMS_W-1:0]     RMS_MAX        = 15'h7FFF;
	localparam logic [MEAN_W-1:0]    MEAN_MAX       = 16'hFFFF;

	// memory requests from the sequencer to the cell store
	typedef struct packed {
		logic rd;
		logic stat_we;
		logic ref_we;
	} mem_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/pna_cell_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pna_cell_store
// Statistics and reference memories, one read and one write port each,
// registered read data; zero-fill sweep after reset.
// ----------------------------------------------------------------------------
module pna_cell_store #(
	parameter int CELLS = 3072,
	parameter int IW    = 12,
	parameter int STW   = 84
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire pna_pkg::mem_ctl_t    ctl,
	input  wire [IW-1:0]              rd_addr,
	input  wire [IW-1:0]              wr_addr,
	input  wire [STW-1:0]             stat_wdata,
	input  wire [pna_pkg::REF_W-1:0]  ref_wdata,
	output logic [STW-1:0]            stat_rdata,
	output logic [pna_pkg::REF_W-1:0] ref_rdata,
	output logic                      clearing
);

	logic [STW-1:0]            stat_mem [CELLS];
	logic [pna_pkg::REF_W-1:0] ref_mem  [CELLS];
	logic [IW-1:0]             clr_addr_q;
	logic                      clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == IW'(CELLS - 1))
				clr_q <= 1'b0;
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			stat_mem[clr_addr_q] <= '0;
			ref_mem[clr_addr_q]  <= '0;
		end else begin
			if (ctl.stat_we)
				stat_mem[wr_addr] <= stat_wdata;
			if (ctl.ref_we)
				ref_mem[wr_addr] <= ref_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			stat_rdata <= stat_mem[rd_addr];
			ref_rdata  <= ref_mem[rd_addr];
		end
	end

	assign clearing = clr_q;

endmodule
`default_nettype wire

// ===== rtl/pna_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pna_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pna_div #(
	parameter int DVW = 32,
	parameter int DSW = 16
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  wire [DVW-1:0]  dividend,
	input  wire [DSW-1:0]  divisor,
	output logic           done,
	output logic [DVW-1:0] quotient
);

	localparam int CW = $clog2(DVW + 1);

	logic [DVW-1:0] quo_q;
	logic [DSW-1:0] rem_q;
	logic [DSW-1:0] dsr_q;
	logic [CW-1:0]  cnt_q;
	logic           run_q;
	logic           done_q;
	logic [DSW:0]   rem_sh;
	logic           fits;

	assign rem_sh = {rem_q, quo_q[DVW-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DVW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? DSW'(rem_sh - {1'b0, dsr_q}) : DSW'(rem_sh);
			quo_q <= {quo_q[DVW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ===== rtl/pna_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pna_sqrt
// Digit-by-digit floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module pna_sqrt #(
	parameter int RW = 32
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  wire [2*RW-1:0]  radicand,
	output logic            done,
	output logic [RW-1:0]   root
);

	localparam int CW = $clog2(RW + 1);

	logic [2*RW-1:0] val_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;
	logic [CW-1:0]   cnt_q;
	logic            run_q;
	logic            done_q;
	logic [RW+3:0]   rem_sh;
	logic [RW+3:0]   trial;
	logic            fits;

	assign rem_sh = {rem_q, val_q[2*RW-1 -: 2]};
	assign trial  = (RW+4)'({root_q, 2'b01});
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(RW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			val_q  <= {val_q[2*RW-3:0], 2'b00};
			rem_q  <= fits ? (RW+2)'(rem_sh - trial) : (RW+2)'(rem_sh);
			root_q <= {root_q[RW-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

// ===== rtl/pedestal_noise_accumulator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pedestal_noise_accumulator
// Per-cell sample count, sum and sum of squares with reference cut; reads
// return mean and rms in 1/16 ADC units.
// ----------------------------------------------------------------------------
//  channel   direction  signals
//  command   in         start/busy, command channel time_bin adc ref_pedestal ref_noise
//  result    out        done, status mean rms count
//  config    in         wr_en, wr_index wr_data
//
//  Load: the reference of a valid cell is written on acceptance. Accumulate: memory read,
//  then modify and write. Read: memory read, multiply, mean divide, square root and
//  rms divide, both divides on one shared divider, each unit one bit per cycle;
//  an empty cell or nonpositive variance ends early.
//  After reset a clearing pass over all CHANNELS*TIME_BINS cells holds busy high.
//  The result strobe done lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module pedestal_noise_accumulator #(
	parameter int CHANNELS   = pna_pkg::CHANNELS_DEF,
	parameter int TIME_BINS  = pna_pkg::TIME_BINS_DEF,
	parameter int ADC_BITS   = pna_pkg::ADC_BITS_DEF,
	parameter int COUNT_BITS = pna_pkg::COUNT_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire [pna_pkg::CMD_W-1:0]     command,
	input  wire [pna_pkg::CHAN_W-1:0]    channel,
	input  wire [pna_pkg::TB_W-1:0]      time_bin,
	input  wire [pna_pkg::ADC_W-1:0]     adc,
	input  wire [pna_pkg::PED_W-1:0]     ref_pedestal,
	input  wire [pna_pkg::NOISE_W-1:0]   ref_noise,
	output logic                         done,
	output logic [pna_pkg::STATUS_W-1:0] status,
	output logic [pna_pkg::MEAN_W-1:0]   mean,
	output logic [pna_pkg::RMS_W-1:0]    rms,
	output logic [pna_pkg::COUNT_W-1:0]  count,
	input  wire                          wr_en,
	input  wire [pna_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire [pna_pkg::CFG_DAT_W-1:0] wr_data
);

	localparam int CELLS = CHANNELS * TIME_BINS;
	localparam int IW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CNW   = COUNT_BITS;
	localparam int SUMW  = ADC_BITS + COUNT_BITS;
	localparam int SQW   = 2 * ADC_BITS + COUNT_BITS;
	localparam int STW   = CNW + SUMW + SQW;
	localparam int PW    = 2 * SUMW;
	localparam int RW    = (PW + 8) / 2;
	localparam int DVW   = SUMW + 4;
	localparam int AXW   = (ADC_BITS > pna_pkg::ADC_W) ? ADC_BITS : pna_pkg::ADC_W;
	localparam int CMPW  = (ADC_BITS + 8 > 21) ? ADC_BITS + 8 : 21;
	localparam logic [CNW-1:0] COUNT_MAX = '1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ACC  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_DIVM = 3'd4;
	localparam logic [2:0] S_SQRT = 3'd5;
	localparam logic [2:0] S_DIVR = 3'd6;

	// configuration
	logic                          cut_en_q;
	logic [pna_pkg::CFG_DAT_W-1:0] cut_f_q;
	logic                          merge_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_en_q <= 1'b1;
			cut_f_q  <= pna_pkg::CUT_FACTOR_RST;
			merge_q  <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				pna_pkg::CFG_CUT_EN: cut_en_q <= wr_data[0];
				pna_pkg::CFG_CUT_F:  cut_f_q  <= wr_data;
				pna_pkg::CFG_MERGE:  merge_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	// request decode
	logic [2:0]              state_q;
	logic                    clearing;
	logic                    accept;
	logic [pna_pkg::TB_W-1:0] tb_eff;
	logic                    cell_ok;
	logic [IW-1:0]           idx;
	logic [AXW-1:0]          adc_x;
	logic [ADC_BITS-1:0]     adc_v;

	assign busy    = clearing || (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign tb_eff  = (command == pna_pkg::CMD_ACC && merge_q) ? '0 : time_bin;
	assign cell_ok = (32'(channel) < 32'(CHANNELS)) && (32'(tb_eff) < 32'(TIME_BINS));
	assign idx     = IW'(32'(channel) * 32'(TIME_BINS) + 32'(tb_eff));
	assign adc_x   = AXW'(adc) & AXW'((64'd1 << ADC_BITS) - 64'd1);
	assign adc_v   = ADC_BITS'(adc_x);

	// cell store
	pna_pkg::mem_ctl_t         ctl;
	logic [IW-1:0]             idx_q;
	logic [IW-1:0]             wr_addr;
	logic [STW-1:0]            stat_rdata;
	logic [STW-1:0]            stat_wdata;
	logic [pna_pkg::REF_W-1:0] ref_rdata;

	logic                valid_q;
	logic [ADC_BITS-1:0] adc_q;

	logic [CNW-1:0]  r_cnt;
	logic [SUMW-1:0] r_sum;
	logic [SQW-1:0]  r_sq;
	logic [CMPW-1:0] adc_scaled;
	logic [CMPW-1:0] limit;
	logic            is_zero;
	logic            is_cut;
	logic            is_sat;

	assign r_cnt = stat_rdata[CNW-1:0];
	assign r_sum = stat_rdata[CNW +: SUMW];
	assign r_sq  = stat_rdata[CNW+SUMW +: SQW];

	assign adc_scaled = CMPW'({adc_q, 8'b0});
	assign limit = CMPW'({ref_rdata[pna_pkg::REF_W-1 -: pna_pkg::PED_W], 4'b0})
		+ CMPW'(cut_f_q) * CMPW'(ref_rdata[pna_pkg::NOISE_W-1:0]);
	assign is_zero = !valid_q || (adc_q == '0);
	assign is_cut  = cut_en_q && (adc_scaled >= limit);
	assign is_sat  = (r_cnt == COUNT_MAX);

	assign stat_wdata = {r_sq + SQW'(adc_q) * SQW'(adc_q), r_sum + SUMW'(adc_q),
		r_cnt + 1'b1};

	always_comb begin
		ctl.rd      = accept && (command == pna_pkg::CMD_ACC || command == pna_pkg::CMD_READ);
		ctl.ref_we  = accept && (command == pna_pkg::CMD_LOAD) && cell_ok;
		ctl.stat_we = (state_q == S_ACC) && !is_zero && !is_cut && !is_sat;
	end

	assign wr_addr = (state_q == S_ACC) ? idx_q : idx;

	pna_cell_store #(
		.CELLS (CELLS),
		.IW    (IW),
		.STW   (STW)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.rd_addr    (idx),
		.wr_addr    (wr_addr),
		.stat_wdata (stat_wdata),
		.ref_wdata  ({ref_pedestal, ref_noise}),
		.stat_rdata (stat_rdata),
		.ref_rdata  (ref_rdata),
		.clearing   (clearing)
	);

	// read arithmetic
	logic [CNW-1:0]  n_q;
	logic [SUMW-1:0] s_q;
	logic [SQW-1:0]  sq_q;
	logic [PW-1:0]   nq_s1;
	logic [PW-1:0]   ss_s1;
	logic            div_start;
	logic [DVW-1:0]  div_dvd;
	logic            div_done;
	logic [DVW-1:0]  div_quo;
	logic            sqrt_start;
	logic            sqrt_done;
	logic [RW-1:0]   sqrt_root;
	logic [CNW-1:0]  n_rd;

	assign n_rd       = valid_q ? r_cnt : '0;
	assign div_start  = (state_q == S_MUL) || (state_q == S_SQRT && sqrt_done);
	assign div_dvd    = (state_q == S_MUL) ? {s_q, 4'b0} : DVW'(sqrt_root);
	assign sqrt_start = (state_q == S_DIVM) && div_done && (nq_s1 > ss_s1);

	pna_div #(
		.DVW (DVW),
		.DSW (CNW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (n_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	pna_sqrt #(
		.RW (RW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand ({nq_s1 - ss_s1, 8'b0}),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// sequencer and result registers
	logic                         done_q;
	logic [pna_pkg::STATUS_W-1:0] status_q;
	logic [pna_pkg::MEAN_W-1:0]   mean_q;
	logic [pna_pkg::RMS_W-1:0]    rms_q;
	logic [pna_pkg::COUNT_W-1:0]  count_q;
	logic [pna_pkg::COUNT_W-1:0]  count_sat;
	logic [pna_pkg::MEAN_W-1:0]   mean_sat;
	logic [pna_pkg::RMS_W-1:0]    rms_sat;

	assign count_sat = (64'(n_q) > 64'(pna_pkg::MEAN_MAX)) ? '1 : pna_pkg::COUNT_W'(n_q);
	assign mean_sat  = (64'(div_quo) > 64'(pna_pkg::MEAN_MAX)) ? pna_pkg::MEAN_MAX
		: pna_pkg::MEAN_W'(div_quo);
	assign rms_sat   = (64'(div_quo) > 64'(pna_pkg::RMS_MAX)) ? pna_pkg::RMS_MAX
		: pna_pkg::RMS_W'(div_quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						valid_q <= cell_ok;
						unique case (command)
							pna_pkg::CMD_LOAD: done_q  <= 1'b1;
							pna_pkg::CMD_ACC:  state_q <= S_ACC;
							pna_pkg::CMD_READ: state_q <= S_RD;
							default: ;
						endcase
					end
				end
				S_ACC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RD: begin
					if (n_rd == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_DIVM;
				S_DIVM: begin
					if (div_done) begin
						if (nq_s1 > ss_s1) begin
							state_q <= S_SQRT;
						end else begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_SQRT: begin
					if (sqrt_done)
						state_q <= S_DIVR;
				end
				S_DIVR: begin
					if (div_done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			idx_q    <= idx;
			adc_q    <= adc_v;
			status_q <= pna_pkg::ST_LOAD;
			mean_q   <= '0;
			rms_q    <= '0;
			count_q  <= '0;
		end
		if (state_q == S_ACC) begin
			if (is_zero)
				status_q <= pna_pkg::ST_ZERO;
			else if (is_cut)
				status_q <= pna_pkg::ST_CUT;
			else if (is_sat)
				status_q <= pna_pkg::ST_SAT;
			else
				status_q <= pna_pkg::ST_ACC;
		end
		if (state_q == S_RD) begin
			n_q      <= n_rd;
			s_q      <= r_sum;
			sq_q     <= r_sq;
			status_q <= pna_pkg::ST_READ;
			// empty cell reads as dead
			mean_q   <= '0;
			rms_q    <= pna_pkg::DEAD_RMS;
			count_q  <= '0;
		end
		if (state_q == S_MUL) begin
			nq_s1   <= PW'(n_q * sq_q);
			ss_s1   <= PW'(s_q * s_q);
			count_q <= count_sat;
		end
		if (state_q == S_DIVM && div_done)
			mean_q <= mean_sat;
		if (state_q == S_DIVR && div_done)
			rms_q <= rms_sat;
	end

	assign done   = done_q;
	assign status = status_q;
	assign mean   = mean_q;
	assign rms    = rms_q;
	assign count  = count_q;

	a_acc_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC) |=> done_q)
		else $error("accumulate request gave no result");

	a_non_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != pna_pkg::ST_READ) |-> (mean_q == '0 && rms_q == '0
			&& count_q == '0))
		else $error("read fields set on a non-read result");

	a_empty_dead: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == pna_pkg::ST_READ && count_q == '0)
			|-> (rms_q == pna_pkg::DEAD_RMS && mean_q == '0))
		else $error("empty cell not reported dead");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (busy && !ctl.stat_we && !ctl.ref_we))
		else $error("request taken during clearing pass");

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_start && sqrt_start))
		else $error("divider and root started together");

endmodule
`default_nettype wire

// ===== bench/pna_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pna_checker
// Watches the command, result and register ports of the pedestal and noise
// accumulator. Keeps its own cell statistics and references, predicts the
// result of each accepted request and compares the results in order.
// ----------------------------------------------------------------------------
module pna_checker
	import pna_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire                   busy,
	input  wire [CMD_W-1:0]       command,
	input  wire [CHAN_W-1:0]      channel,
	input  wire [TB_W-1:0]        time_bin,
	input  wire [ADC_W-1:0]       adc,
	input  wire [PED_W-1:0]       ref_pedestal,
	input  wire [NOISE_W-1:0]     ref_noise,
	input  wire                   done,
	input  wire [STATUS_W-1:0]    status,
	input  wire [MEAN_W-1:0]      mean,
	input  wire [RMS_W-1:0]       rms,
	input  wire [COUNT_W-1:0]     count,
	input  wire                   wr_en,
	input  wire [CFG_IDX_W-1:0]   wr_index,
	input  wire [CFG_DAT_W-1:0]   wr_data,
	output int                    errors,
	output int                    pending
);

	localparam int NCHAN  = CHANNELS_DEF;
	localparam int NBINS  = TIME_BINS_DEF;
	localparam int NCELLS = NCHAN * NBINS;
	localparam logic [15:0] COUNT_TOP = 16'hFFFF;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [MEAN_W-1:0]   mean;
		logic [RMS_W-1:0]    rms;
		logic [COUNT_W-1:0]  count;
	} outcome_t;

	outcome_t outcome_q[$];

	bit [15:0]      cell_n   [NCELLS];
	bit [27:0]      cell_sum [NCELLS];
	bit [39:0]      cell_sq  [NCELLS];
	bit [PED_W-1:0] cell_ped [NCELLS];
	bit [NOISE_W-1:0] cell_noise [NCELLS];

	bit       cut_on;
	bit [7:0] cut_mult;
	bit       merge_on;

	function automatic bit [63:0] floor_root(input bit [127:0] v);
		bit [63:0]  root;
		bit [63:0]  trial;
		bit [127:0] sqr;
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			sqr = 128'(trial) * 128'(trial);
			if (sqr <= v)
				root = trial;
		end
		return root;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// computes the result of one request and updates the predicted cell store
	task automatic predict_request(output bit has_result, output outcome_t o);
		bit [1:0]   bin;
		bit         in_range;
		int         idx;
		bit [31:0]  limit;
		bit [63:0]  n, s, q, avg, root;
		bit [127:0] nq, ss, d;
		has_result = 1'b1;
		o = '0;
		bin = time_bin;
		if (command == CMD_ACC && merge_on)
			bin = '0;
		in_range = (int'(channel) < NCHAN) && (int'(bin) < NBINS);
		idx = int'(channel) * NBINS + int'(bin);
		case (command)
			CMD_LOAD: begin
				if (in_range) begin
					cell_ped[idx] = ref_pedestal;
					cell_noise[idx] = ref_noise;
				end
				o.status = ST_LOAD;
			end
			CMD_ACC: begin
				limit = 32'(cell_ped[idx]) * 16 + 32'(cut_mult) * 32'(cell_noise[idx]);
				if (!in_range || adc == '0)
					o.status = ST_ZERO;
				else if (cut_on && 32'(adc) * 256 >= limit)
					o.status = ST_CUT;
				else if (cell_n[idx] == COUNT_TOP)
					o.status = ST_SAT;
				else begin
					cell_n[idx]++;
					cell_sum[idx] += 28'(adc);
					cell_sq[idx] += 40'(adc) * 40'(adc);
					o.status = ST_ACC;
				end
			end
			CMD_READ: begin
				o.status = ST_READ;
				n = in_range ? 64'(cell_n[idx]) : 64'd0;
				if (n == 0)
					o.rms = DEAD_RMS;
				else begin
					s = 64'(cell_sum[idx]);
					q = 64'(cell_sq[idx]);
					avg = (s * 16) / n;
					o.mean = (avg > 64'(MEAN_MAX)) ? MEAN_MAX : avg[MEAN_W-1:0];
					nq = 128'(n) * 128'(q);
					ss = 128'(s) * 128'(s);
					if (nq > ss) begin
						d = (nq - ss) << 8;
						root = floor_root(d) / n;
						o.rms = (root > 64'(RMS_MAX)) ? RMS_MAX : root[RMS_W-1:0];
					end else
						o.rms = DEAD_RMS;
					o.count = n[COUNT_W-1:0];
				end
			end
			default: has_result = 1'b0;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t o;
		outcome_t want;
		bit       has_result;
		if (!arst_n) begin
			cut_on <= 1'b1;
			cut_mult <= CUT_FACTOR_RST;
			merge_on <= 1'b0;
		end else begin
			if (done) begin
				if (outcome_q.size() == 0) begin
					report("unexpected result status", status, -1);
				end else begin
					want = outcome_q.pop_front();
					if (status !== want.status) report("status", status, want.status);
					if (mean !== want.mean) report("mean", mean, want.mean);
					if (rms !== want.rms) report("rms", rms, want.rms);
					if (count !== want.count) report("count", count, want.count);
				end
			end
			if (start && !busy) begin
				predict_request(has_result, o);
				if (has_result)
					outcome_q.push_back(o);
			end
			pending = outcome_q.size();
			if (wr_en) begin
				case (wr_index)
					CFG_CUT_EN: cut_on <= wr_data[0];
					CFG_CUT_F:  cut_mult <= wr_data;
					CFG_MERGE:  merge_on <= wr_data[0];
					default: ;
				endcase
			end
		end
	end

	initial begin
		errors = 0;
		pending = 0;
	end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Drives the pedestal and noise accumulator with directed and random load,
// accumulate and read requests under several register settings. Results
// are checked by pna_checker.
// ----------------------------------------------------------------------------
module tb;
	import pna_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 120;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [CMD_W-1:0]     command = '0;
	logic [CHAN_W-1:0]    channel = '0;
	logic [TB_W-1:0]      time_bin = '0;
	logic [ADC_W-1:0]     adc = '0;
	logic [PED_W-1:0]     ref_pedestal = '0;
	logic [NOISE_W-1:0]   ref_noise = '0;
	logic                 done;
	logic [STATUS_W-1:0]  status;
	logic [MEAN_W-1:0]    mean;
	logic [RMS_W-1:0]     rms;
	logic [COUNT_W-1:0]   count;
	logic                 wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = '0;
	logic [CFG_DAT_W-1:0] wr_data = '0;
	int                   errors;
	int                   pending;
	int                   cycles = 0;

	always #10 clk = ~clk;

	pedestal_noise_accumulator i_dut (
		.clk, .arst_n, .start, .busy, .command, .channel, .time_bin, .adc,
		.ref_pedestal, .ref_noise, .done, .status, .mean, .rms, .count,
		.wr_en, .wr_index, .wr_data
	);

	pna_checker i_check (
		.clk, .arst_n, .start, .busy, .command, .channel, .time_bin, .adc,
		.ref_pedestal, .ref_noise, .done, .status, .mean, .rms, .count,
		.wr_en, .wr_index, .wr_data, .errors, .pending
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// called at a rising edge; returns at the edge that accepts the request
	task automatic send(input logic [CMD_W-1:0] c, input int ch, input int bin,
			input int a, input int ped, input int nz);
		start <= 1'b1;
		command <= c;
		channel <= CHAN_W'(ch);
		time_bin <= TB_W'(bin);
		adc <= ADC_W'(a);
		ref_pedestal <= PED_W'(ped);
		ref_noise <= NOISE_W'(nz);
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic pause(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= CFG_DAT_W'(val);
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic configure(input int cut_en, input int factor, input int merge);
		wait_drained();
		cfg_write(CFG_CUT_EN, cut_en);
		cfg_write(CFG_CUT_F, factor);
		cfg_write(CFG_MERGE, merge);
	endtask

	// mostly a few busy cells with samples near their pedestal, plus noise
	task automatic random_request(input bit idling);
		int r, ch, bin, a, ped, nz;
		logic [CMD_W-1:0] c;
		r = $urandom_range(99);
		c = (r < 10) ? CMD_LOAD : (r < 78) ? CMD_ACC : (r < 96) ? CMD_READ : CMD_UNUSED;
		ch = ($urandom_range(9) < 7) ? (($urandom_range(1) ? 1016 : 0) + $urandom_range(7))
			: $urandom_range(1023);
		bin = ($urandom_range(9) == 0) ? 3 : $urandom_range(2);
		r = $urandom_range(99);
		a = (r < 5) ? 0 : (r < 20) ? $urandom_range(4095) : $urandom_range(90, 160);
		if ($urandom_range(9) < 6) begin
			ped = $urandom_range(1600, 2600);
			nz = $urandom_range(200);
		end else begin
			ped = $urandom_range(65535);
			nz = $urandom_range(4095);
		end
		send(c, ch, bin, a, ped, nz);
		if (idling && $urandom_range(5) == 0)
			pause($urandom_range(1, 15));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty cells, zero sample, unloaded cell under the cut
		send(CMD_READ, 0, 0, 0, 0, 0);
		send(CMD_ACC, 0, 0, 0, 0, 0);
		send(CMD_ACC, 0, 0, 4095, 0, 0);
		send(CMD_LOAD, 0, 0, 0, 65535, 4095);
		send(CMD_LOAD, 1023, 3, 4095, 65535, 4095);
		send(CMD_LOAD, 1023, 2, 0, 0, 0);
		send(CMD_ACC, 0, 0, 4095, 0, 0);
		send(CMD_READ, 0, 0, 0, 0, 0);
		send(CMD_ACC, 0, 0, 1, 0, 0);
		send(CMD_ACC, 0, 0, 2048, 0, 0);
		send(CMD_READ, 0, 0, 0, 0, 0);
		send(CMD_ACC, 1023, 3, 100, 0, 0);
		send(CMD_READ, 1023, 3, 0, 0, 0);
		send(CMD_ACC, 1023, 2, 1, 0, 0);
		send(CMD_UNUSED, 5, 1, 7, 9, 9);
		send(CMD_LOAD, 2, 1, 0, 1600, 100);
		send(CMD_ACC, 2, 1, 118, 0, 0);
		send(CMD_ACC, 2, 1, 119, 0, 0);
		send(CMD_ACC, 2, 1, 117, 0, 0);
		send(CMD_READ, 2, 1, 0, 0, 0);
		pause(3);

		configure(1, 48, 0);
		repeat (106) random_request(1'b1);
		configure(0, 255, 1);
		repeat (106) random_request(1'b1);
		configure(1, 0, 1);
		repeat (106) random_request(1'b1);
		configure(1, 255, 0);
		repeat (106) random_request(1'b1);
		configure(1, $urandom_range(1, 254), 0);
		repeat (106) random_request(1'b0);

		wait_drained();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// ===== pedestal_noise_accumulator.f =====
rtl/pna_pkg.sv
rtl/pna_cell_store.sv
rtl/pna_div.sv
rtl/pna_sqrt.sv
rtl/pedestal_noise_accumulator.sv
bench/pna_checker.sv
bench/tb.sv
